// ===== rtl/rrca_pkg.sv =====
`timescale 1ns / 1ps
// rrca_pkg: operation codes, status codes and sequencer state type
// for the round robin context allocator; no dependencies

package rrca_pkg;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] STAT_OK           = 2'd0;
	localparam logic [1:0] STAT_NO_FREE      = 2'd1;
	localparam logic [1:0] STAT_ALREADY_FREE = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

endpackage

// ===== rtl/round_robin_context_allocator.sv =====
`timescale 1ns / 1ps
// round_robin_context_allocator: next-fit slot allocator with owner table
// and busy count; depends on rrca_pkg
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------
//  in      | in_valid / in_stall  | op, owner_id, slot_index
//  out     | out_valid / out_stall| status, granted_slot, any_busy
//
// an accepted beat is worked on in the exec state, then the block is back in
// idle; the block takes no new beat until then. allocate scans the table in
// the shared window of up to 8 lanes, which scans up to 8 slots a cycle.
// reset clears every owned bit, the busy count and the last grant pointer
// at once; the owner table is not cleared.
// a result waits in the output register; a stalled output holds the final
// step of the next beat, earlier scan steps still go on.

module round_robin_context_allocator #(
	parameter int NUM_SLOTS  = 32,
	parameter int OWNER_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [15:0] owner_id,
	input  logic [4:0] slot_index,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [4:0] granted_slot,
	output logic       any_busy
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam int LANES = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;

	rrca_pkg::state_t st_q;

	logic [1:0]            op_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic                  free_ok_q;
	logic [IDX_W-1:0]      cur_q;
	logic [CNT_W-1:0]      rem_q;
	logic [IDX_W-1:0]      last_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [NUM_SLOTS-1:0]  slot_owned_q;
	logic [OWNER_BITS-1:0] owner_mem [NUM_SLOTS];

	logic       out_valid_q;
	logic [1:0] status_q;
	logic [4:0] granted_q;
	logic       any_busy_q;

	logic [IDX_W:0]   lane_sum [LANES];
	logic [IDX_W-1:0] lane_idx [LANES];
	logic [LANES-1:0] lane_free;
	logic             found;
	logic [IDX_W-1:0] grant_idx;
	logic             scan_last;
	logic             out_free;
	logic             accept;
	logic             commit;
	logic             advance;
	logic             free_hit;
	logic [1:0]       res_status;
	logic [CNT_W-1:0] cnt_next;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (st_q != rrca_pkg::S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// window of slots cur+1 .. cur+LANES, wrapped once
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			lane_sum[k] = {1'b0, cur_q} + (IDX_W + 1)'(k + 1);
			if (lane_sum[k] >= (IDX_W + 1)'(NUM_SLOTS)) begin
				lane_sum[k] = lane_sum[k] - (IDX_W + 1)'(NUM_SLOTS);
			end
			lane_idx[k]  = lane_sum[k][IDX_W-1:0];
			lane_free[k] = (CNT_W'(k) < rem_q) && !slot_owned_q[lane_idx[k]];
		end
	end

	// first free lane wins
	always_comb begin
		found     = 1'b0;
		grant_idx = lane_idx[0];
		for (int k = LANES - 1; k >= 0; k--) begin
			if (lane_free[k]) begin
				found     = 1'b1;
				grant_idx = lane_idx[k];
			end
		end
	end

	assign scan_last = (rem_q <= CNT_W'(LANES));
	assign free_hit  = free_ok_q && slot_owned_q[free_idx_q];
	assign commit    = (st_q == rrca_pkg::S_EXEC) && out_free &&
		((op_q != rrca_pkg::OP_ALLOC) || found || scan_last);
	assign advance   = (st_q == rrca_pkg::S_EXEC) && (op_q == rrca_pkg::OP_ALLOC) &&
		!found && !scan_last;

	always_comb begin
		res_status = rrca_pkg::STAT_OK;
		cnt_next   = cnt_q;
		case (op_q)
			rrca_pkg::OP_ALLOC: begin
				if (found) begin
					cnt_next = cnt_q + CNT_W'(1);
				end else begin
					res_status = rrca_pkg::STAT_NO_FREE;
				end
			end
			rrca_pkg::OP_FREE: begin
				if (free_hit) begin
					cnt_next = cnt_q - CNT_W'(1);
				end else begin
					res_status = rrca_pkg::STAT_ALREADY_FREE;
				end
			end
			default: begin
				res_status = rrca_pkg::STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= rrca_pkg::S_IDLE;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
			slot_owned_q <= '0;
			last_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				rrca_pkg::S_IDLE: begin
					if (in_valid) begin
						st_q <= rrca_pkg::S_EXEC;
					end
				end
				rrca_pkg::S_EXEC: begin
					if (commit) begin
						st_q        <= rrca_pkg::S_IDLE;
						out_valid_q <= 1'b1;
						cnt_q       <= cnt_next;
						if (op_q == rrca_pkg::OP_ALLOC && found) begin
							slot_owned_q[grant_idx] <= 1'b1;
							last_q                  <= grant_idx;
						end
						if (op_q == rrca_pkg::OP_FREE && free_hit) begin
							slot_owned_q[free_idx_q] <= 1'b0;
						end
					end
				end
				default: begin
					st_q <= rrca_pkg::S_IDLE;
				end
			endcase
		end
	end

	// beat capture and scan window
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op;
			owner_q    <= OWNER_BITS'(owner_id);
			free_idx_q <= IDX_W'(slot_index);
			free_ok_q  <= (32'(slot_index) < 32'(NUM_SLOTS));
			cur_q      <= last_q;
			rem_q      <= CNT_W'(NUM_SLOTS);
		end else if (advance) begin
			cur_q <= lane_idx[LANES-1];
			rem_q <= rem_q - CNT_W'(LANES);
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q   <= res_status;
			granted_q  <= (op_q == rrca_pkg::OP_ALLOC && found) ? 5'(grant_idx) : 5'd0;
			any_busy_q <= (cnt_next != '0);
		end
	end

	// owner table, written on grant
	always_ff @(posedge clk) begin
		if (commit && op_q == rrca_pkg::OP_ALLOC && found) begin
			owner_mem[grant_idx] <= owner_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_slot = granted_q;
	assign any_busy     = any_busy_q;

	a_cnt_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) == $countones(slot_owned_q))
		else $error("busy count out of step with owned bits");

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == rrca_pkg::S_EXEC && op_q == rrca_pkg::OP_ALLOC) |-> rem_q != '0)
		else $error("scan ran past the table");

	a_grant_was_free: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && op_q == rrca_pkg::OP_ALLOC && found) |->
		!slot_owned_q[grant_idx])
		else $error("grant of an owned slot");

	a_grant_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && op_q == rrca_pkg::OP_ALLOC && found) |=>
		slot_owned_q[last_q] && owner_mem[last_q] == $past(owner_q))
		else $error("granted slot not recorded");

	a_busy_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> any_busy_q == (slot_owned_q != '0))
		else $error("reported busy flag differs from table");

endmodule
